/* src/dpd_pkg.sv */
// Shared types, register indexes and saturation helpers for the dual PD drive controller.
`default_nettype none

package dpd_pkg;

  // Field and port widths
  localparam int unsigned DataW  = 32;
  localparam int unsigned GainW  = 31;
  localparam int unsigned DriveW = 33;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned ProdW  = 64;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_LAT_P_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LAT_D_GAIN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TURN_P_GAIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TURN_D_GAIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DIST_TARGET  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HEAD_TARGET  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_LAT_LIMIT    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_TURN_LIMIT   = 3'd7;

  // Register reset values
  localparam logic [GainW-1:0] RST_LAT_P_GAIN  = 31'd6553600;
  localparam logic [GainW-1:0] RST_LAT_D_GAIN  = 31'd0;
  localparam logic [GainW-1:0] RST_TURN_P_GAIN = 31'd8520;
  localparam logic [GainW-1:0] RST_TURN_D_GAIN = 31'd6554;
  localparam logic [DataW-1:0] RST_DIST_TARGET = 32'd0;
  localparam logic [DataW-1:0] RST_HEAD_TARGET = 32'd17694720;
  localparam logic [GainW-1:0] RST_LAT_LIMIT   = 31'd393216;
  localparam logic [GainW-1:0] RST_TURN_LIMIT  = 31'd589824;

  // Settle tolerances and counter thresholds
  localparam logic signed [DataW-1:0] CLOSE_TOL    = 32'sd655;
  localparam logic signed [DataW-1:0] TURN_DER_TOL = 32'sd6553;
  localparam logic signed [DataW-1:0] STILL_TOL    = 32'sd327;
  localparam logic [2:0] CLOSE_NEED = 3'd5;
  localparam logic [5:0] STILL_NEED = 6'd35;

  // Load strobes of each pipeline stage, from the pipeline controller
  typedef struct packed {
    logic ld_in;
    logic ld_err;
    logic ld_der;
    logic ld_prod;
    logic ld_term;
    logic ld_pow;
    logic ld_out;
  } pipe_ctrl_t;

  // Saturate a 33-bit signed value to 32 bits.
  function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] v);
    logic signed [DataW-1:0] res;
    if (v[DataW] != v[DataW-1]) begin
      res = v[DataW] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      res = v[DataW-1:0];
    end
    return res;
  endfunction

  // Saturate a 48-bit signed value to 32 bits.
  function automatic logic signed [DataW-1:0] sat48(input logic signed [47:0] v);
    logic signed [DataW-1:0] res;
    if ((&v[47:31]) || !(|v[47:31])) begin
      res = v[DataW-1:0];
    end else begin
      res = v[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/dpd_pipe_ctrl.sv */
// Pipeline valid tracking and per-stage load strobes with bubble collapsing.
`default_nettype none

module dpd_pipe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output dpd_pkg::pipe_ctrl_t    ctrl
);

  localparam int unsigned NStages = 7;

  logic [NStages:1] vld_r;
  logic [NStages:1] vld_nxt;
  logic [NStages:1] free;
  logic [NStages:1] load;

  // A stage can take a new item when it is empty or its item moves on.
  always_comb begin
    free[NStages] = !vld_r[NStages] || !out_stall;
    for (int k = NStages - 1; k >= 1; k--) begin
      free[k] = !vld_r[k] || free[k+1];
    end
    load[1] = in_valid && free[1];
    for (int k = 2; k <= NStages; k++) begin
      load[k] = vld_r[k-1] && free[k];
    end
  end

  // Valid bits follow the loads and the drains.
  always_comb begin
    for (int k = 1; k < NStages; k++) begin
      vld_nxt[k] = load[k] || (vld_r[k] && !load[k+1]);
    end
    vld_nxt[NStages] = load[NStages] || (vld_r[NStages] && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall     = !free[1];
  assign out_valid    = vld_r[NStages];
  assign ctrl.ld_in   = load[1];
  assign ctrl.ld_err  = load[2];
  assign ctrl.ld_der  = load[3];
  assign ctrl.ld_prod = load[4];
  assign ctrl.ld_term = load[5];
  assign ctrl.ld_pow  = load[6];
  assign ctrl.ld_out  = load[7];

endmodule

`default_nettype wire

/* src/dpd_err.sv */
// Error and derivative stages, last-error state and the settle counters.
`default_nettype none

module dpd_err (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire dpd_pkg::pipe_ctrl_t               ctrl,
  input  wire logic signed [dpd_pkg::DataW-1:0]  left_s1,
  input  wire logic signed [dpd_pkg::DataW-1:0]  right_s1,
  input  wire logic signed [dpd_pkg::DataW-1:0]  head_s1,
  input  wire logic signed [dpd_pkg::DataW-1:0]  dist_target,
  input  wire logic signed [dpd_pkg::DataW-1:0]  head_target,
  output logic signed [dpd_pkg::DataW-1:0]       derr_s3,
  output logic signed [dpd_pkg::DataW-1:0]       dder_s3,
  output logic signed [dpd_pkg::DataW-1:0]       herr_s3,
  output logic signed [dpd_pkg::DataW-1:0]       hder_s3,
  output logic                                   settled_nxt
);

  logic signed [dpd_pkg::DataW:0]   pos_sum;
  logic signed [dpd_pkg::DataW-1:0] avg;
  logic signed [dpd_pkg::DataW-1:0] derr_c;
  logic signed [dpd_pkg::DataW-1:0] herr_c;
  logic signed [dpd_pkg::DataW-1:0] dder_c;
  logic signed [dpd_pkg::DataW-1:0] hder_c;

  logic signed [dpd_pkg::DataW-1:0] derr2_r;
  logic signed [dpd_pkg::DataW-1:0] herr2_r;
  logic signed [dpd_pkg::DataW-1:0] derr3_r;
  logic signed [dpd_pkg::DataW-1:0] dder3_r;
  logic signed [dpd_pkg::DataW-1:0] herr3_r;
  logic signed [dpd_pkg::DataW-1:0] hder3_r;

  logic signed [dpd_pkg::DataW-1:0] last_derr_r;
  logic signed [dpd_pkg::DataW-1:0] last_herr_r;
  logic [2:0] close_cnt_r;
  logic [2:0] close_cnt_nxt;
  logic [5:0] still_cnt_r;
  logic [5:0] still_cnt_nxt;
  logic       done_r;
  logic       done_nxt;
  logic       close_ok;
  logic       still_ok;

  // Average rotation rounds toward minus infinity; errors saturate.
  assign pos_sum = {left_s1[dpd_pkg::DataW-1], left_s1}
                 + {right_s1[dpd_pkg::DataW-1], right_s1};
  assign avg     = pos_sum[dpd_pkg::DataW:1];
  assign derr_c  = dpd_pkg::sat33({dist_target[dpd_pkg::DataW-1], dist_target}
                                  - {avg[dpd_pkg::DataW-1], avg});
  assign herr_c  = dpd_pkg::sat33({head_target[dpd_pkg::DataW-1], head_target}
                                  - {head_s1[dpd_pkg::DataW-1], head_s1});

  // Derivatives against the error of the previous item.
  assign dder_c = dpd_pkg::sat33({derr2_r[dpd_pkg::DataW-1], derr2_r}
                                 - {last_derr_r[dpd_pkg::DataW-1], last_derr_r});
  assign hder_c = dpd_pkg::sat33({herr2_r[dpd_pkg::DataW-1], herr2_r}
                                 - {last_herr_r[dpd_pkg::DataW-1], last_herr_r});

  always_ff @(posedge clk) begin
    if (ctrl.ld_err) begin
      derr2_r <= derr_c;
      herr2_r <= herr_c;
    end
    if (ctrl.ld_der) begin
      derr3_r <= derr2_r;
      dder3_r <= dder_c;
      herr3_r <= herr2_r;
      hder3_r <= hder_c;
    end
  end

  // Settle counters advance as an item leaves the derivative stage.
  always_comb begin
    close_ok = (derr3_r <= dpd_pkg::CLOSE_TOL) && (derr3_r >= -dpd_pkg::CLOSE_TOL)
            && (hder3_r <= dpd_pkg::TURN_DER_TOL) && (hder3_r >= -dpd_pkg::TURN_DER_TOL);
    still_ok = (dder3_r <= dpd_pkg::STILL_TOL) && (dder3_r >= -dpd_pkg::STILL_TOL);
    if (!close_ok) begin
      close_cnt_nxt = '0;
    end else if (close_cnt_r < dpd_pkg::CLOSE_NEED) begin
      close_cnt_nxt = close_cnt_r + 3'd1;
    end else begin
      close_cnt_nxt = close_cnt_r;
    end
    if (!still_ok) begin
      still_cnt_nxt = '0;
    end else if (still_cnt_r < dpd_pkg::STILL_NEED) begin
      still_cnt_nxt = still_cnt_r + 6'd1;
    end else begin
      still_cnt_nxt = still_cnt_r;
    end
    done_nxt = done_r || (close_cnt_nxt >= dpd_pkg::CLOSE_NEED)
            || (still_cnt_nxt >= dpd_pkg::STILL_NEED);
  end

  // Loop state: last errors, counters and the sticky done flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_derr_r <= '0;
      last_herr_r <= '0;
      close_cnt_r <= '0;
      still_cnt_r <= '0;
      done_r      <= 1'b0;
    end else begin
      if (ctrl.ld_der) begin
        last_derr_r <= derr2_r;
        last_herr_r <= herr2_r;
      end
      if (ctrl.ld_prod) begin
        close_cnt_r <= close_cnt_nxt;
        still_cnt_r <= still_cnt_nxt;
        done_r      <= done_nxt;
      end
    end
  end

  assign derr_s3     = derr3_r;
  assign dder_s3     = dder3_r;
  assign herr_s3     = herr3_r;
  assign hder_s3     = hder3_r;
  assign settled_nxt = done_nxt;

endmodule

`default_nettype wire

/* src/dpd_pow.sv */
// Gain products, term saturation, loop sums and power clamps.
`default_nettype none

module dpd_pow (
  input  wire logic                              clk,
  input  wire dpd_pkg::pipe_ctrl_t               ctrl,
  input  wire logic signed [dpd_pkg::DataW-1:0]  derr_s3,
  input  wire logic signed [dpd_pkg::DataW-1:0]  dder_s3,
  input  wire logic signed [dpd_pkg::DataW-1:0]  herr_s3,
  input  wire logic signed [dpd_pkg::DataW-1:0]  hder_s3,
  input  wire logic                              settled_nxt,
  input  wire logic [dpd_pkg::GainW-1:0]         lat_p_gain,
  input  wire logic [dpd_pkg::GainW-1:0]         lat_d_gain,
  input  wire logic [dpd_pkg::GainW-1:0]         turn_p_gain,
  input  wire logic [dpd_pkg::GainW-1:0]         turn_d_gain,
  input  wire logic [dpd_pkg::GainW-1:0]         lat_limit,
  input  wire logic [dpd_pkg::GainW-1:0]         turn_limit,
  output logic signed [dpd_pkg::DataW-1:0]       lat_pow,
  output logic signed [dpd_pkg::DataW-1:0]       turn_pow,
  output logic                                   settled_s6
);

  logic signed [dpd_pkg::ProdW-1:0] prod_lp_r;
  logic signed [dpd_pkg::ProdW-1:0] prod_ld_r;
  logic signed [dpd_pkg::ProdW-1:0] prod_tp_r;
  logic signed [dpd_pkg::ProdW-1:0] prod_td_r;
  logic settled4_r;

  logic signed [dpd_pkg::DataW-1:0] term_lp_r;
  logic signed [dpd_pkg::DataW-1:0] term_ld_r;
  logic signed [dpd_pkg::DataW-1:0] term_tp_r;
  logic signed [dpd_pkg::DataW-1:0] term_td_r;
  logic settled5_r;

  logic signed [dpd_pkg::DataW-1:0] lat_sum;
  logic signed [dpd_pkg::DataW-1:0] turn_sum;
  logic signed [dpd_pkg::DataW-1:0] lat_lim_s;
  logic signed [dpd_pkg::DataW-1:0] turn_lim_s;
  logic signed [dpd_pkg::DataW-1:0] lat_clamp;
  logic signed [dpd_pkg::DataW-1:0] turn_clamp;
  logic signed [dpd_pkg::DataW-1:0] lat_pow_r;
  logic signed [dpd_pkg::DataW-1:0] turn_pow_r;
  logic settled6_r;

  // Four independent gain products, one multiplier each.
  always_ff @(posedge clk) begin
    if (ctrl.ld_prod) begin
      prod_lp_r  <= $signed({1'b0, lat_p_gain})  * derr_s3;
      prod_ld_r  <= $signed({1'b0, lat_d_gain})  * dder_s3;
      prod_tp_r  <= $signed({1'b0, turn_p_gain}) * herr_s3;
      prod_td_r  <= $signed({1'b0, turn_d_gain}) * hder_s3;
      settled4_r <= settled_nxt;
    end
  end

  // Dropping the fraction bits floors the product; then saturate to 32 bits.
  always_ff @(posedge clk) begin
    if (ctrl.ld_term) begin
      term_lp_r  <= dpd_pkg::sat48(prod_lp_r[dpd_pkg::ProdW-1:16]);
      term_ld_r  <= dpd_pkg::sat48(prod_ld_r[dpd_pkg::ProdW-1:16]);
      term_tp_r  <= dpd_pkg::sat48(prod_tp_r[dpd_pkg::ProdW-1:16]);
      term_td_r  <= dpd_pkg::sat48(prod_td_r[dpd_pkg::ProdW-1:16]);
      settled5_r <= settled4_r;
    end
  end

  // Loop sums saturate, then each power is clamped to its symmetric limit.
  always_comb begin
    lat_sum    = dpd_pkg::sat33({term_lp_r[dpd_pkg::DataW-1], term_lp_r}
                                + {term_ld_r[dpd_pkg::DataW-1], term_ld_r});
    turn_sum   = dpd_pkg::sat33({term_tp_r[dpd_pkg::DataW-1], term_tp_r}
                                + {term_td_r[dpd_pkg::DataW-1], term_td_r});
    lat_lim_s  = $signed({1'b0, lat_limit});
    turn_lim_s = $signed({1'b0, turn_limit});
    if (lat_sum > lat_lim_s) begin
      lat_clamp = lat_lim_s;
    end else if (lat_sum < -lat_lim_s) begin
      lat_clamp = -lat_lim_s;
    end else begin
      lat_clamp = lat_sum;
    end
    if (turn_sum > turn_lim_s) begin
      turn_clamp = turn_lim_s;
    end else if (turn_sum < -turn_lim_s) begin
      turn_clamp = -turn_lim_s;
    end else begin
      turn_clamp = turn_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_pow) begin
      lat_pow_r  <= lat_clamp;
      turn_pow_r <= turn_clamp;
      settled6_r <= settled5_r;
    end
  end

  assign lat_pow    = lat_pow_r;
  assign turn_pow   = turn_pow_r;
  assign settled_s6 = settled6_r;

endmodule

`default_nettype wire

/* src/dual_pd_drive_controller_unit.sv */
// Top level of the dual PD drive controller: registers, input and result stages.
//
//   Channel  Direction  Handshake             Payload
//   in_      in         in_valid / in_stall   in_left_rotation, in_right_rotation, in_heading
//   out_     out        out_valid / out_stall out_left_drive, out_right_drive, out_settled
//   cfg_     in         cfg_we                cfg_index, cfg_wdata
//
// One item is accepted per cycle while in_stall is low.
// Seven register stages: input, error, derivative, product, term, power, result.
// Synchronous reset clears the valid bits and loop state and presets the config registers.
// A stalled result stage holds; empty stages ahead of it keep filling until the
// pipeline is full, and in_stall rises only then.
`default_nettype none

module dual_pd_drive_controller_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [dpd_pkg::DataW-1:0]    in_left_rotation,
  input  wire logic signed [dpd_pkg::DataW-1:0]    in_right_rotation,
  input  wire logic signed [dpd_pkg::DataW-1:0]    in_heading,
  // Result channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [dpd_pkg::DriveW-1:0]        out_left_drive,
  output logic signed [dpd_pkg::DriveW-1:0]        out_right_drive,
  output logic                                     out_settled,
  // Configuration port
  input  wire logic                                cfg_we,
  input  wire logic [dpd_pkg::CfgIdxW-1:0]         cfg_index,
  input  wire logic [dpd_pkg::DataW-1:0]           cfg_wdata
);

  dpd_pkg::pipe_ctrl_t ctrl;

  logic [dpd_pkg::GainW-1:0] lat_p_gain_r;
  logic [dpd_pkg::GainW-1:0] lat_d_gain_r;
  logic [dpd_pkg::GainW-1:0] turn_p_gain_r;
  logic [dpd_pkg::GainW-1:0] turn_d_gain_r;
  logic [dpd_pkg::DataW-1:0] dist_target_r;
  logic [dpd_pkg::DataW-1:0] head_target_r;
  logic [dpd_pkg::GainW-1:0] lat_limit_r;
  logic [dpd_pkg::GainW-1:0] turn_limit_r;

  logic signed [dpd_pkg::DataW-1:0] left_r;
  logic signed [dpd_pkg::DataW-1:0] right_r;
  logic signed [dpd_pkg::DataW-1:0] head_r;

  logic signed [dpd_pkg::DataW-1:0] derr_s3;
  logic signed [dpd_pkg::DataW-1:0] dder_s3;
  logic signed [dpd_pkg::DataW-1:0] herr_s3;
  logic signed [dpd_pkg::DataW-1:0] hder_s3;
  logic settled_nxt;

  logic signed [dpd_pkg::DataW-1:0] lat_pow;
  logic signed [dpd_pkg::DataW-1:0] turn_pow;
  logic settled_s6;

  logic signed [dpd_pkg::DriveW-1:0] left_drive_r;
  logic signed [dpd_pkg::DriveW-1:0] right_drive_r;
  logic settled_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_p_gain_r  <= dpd_pkg::RST_LAT_P_GAIN;
      lat_d_gain_r  <= dpd_pkg::RST_LAT_D_GAIN;
      turn_p_gain_r <= dpd_pkg::RST_TURN_P_GAIN;
      turn_d_gain_r <= dpd_pkg::RST_TURN_D_GAIN;
      dist_target_r <= dpd_pkg::RST_DIST_TARGET;
      head_target_r <= dpd_pkg::RST_HEAD_TARGET;
      lat_limit_r   <= dpd_pkg::RST_LAT_LIMIT;
      turn_limit_r  <= dpd_pkg::RST_TURN_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        dpd_pkg::REG_LAT_P_GAIN:  lat_p_gain_r  <= cfg_wdata[dpd_pkg::GainW-1:0];
        dpd_pkg::REG_LAT_D_GAIN:  lat_d_gain_r  <= cfg_wdata[dpd_pkg::GainW-1:0];
        dpd_pkg::REG_TURN_P_GAIN: turn_p_gain_r <= cfg_wdata[dpd_pkg::GainW-1:0];
        dpd_pkg::REG_TURN_D_GAIN: turn_d_gain_r <= cfg_wdata[dpd_pkg::GainW-1:0];
        dpd_pkg::REG_DIST_TARGET: dist_target_r <= cfg_wdata;
        dpd_pkg::REG_HEAD_TARGET: head_target_r <= cfg_wdata;
        dpd_pkg::REG_LAT_LIMIT:   lat_limit_r   <= cfg_wdata[dpd_pkg::GainW-1:0];
        dpd_pkg::REG_TURN_LIMIT:  turn_limit_r  <= cfg_wdata[dpd_pkg::GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline control
  dpd_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (ctrl.ld_in) begin
      left_r  <= in_left_rotation;
      right_r <= in_right_rotation;
      head_r  <= in_heading;
    end
  end

  // Errors, derivatives and settle tracking
  dpd_err u_err (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .left_s1     (left_r),
    .right_s1    (right_r),
    .head_s1     (head_r),
    .dist_target ($signed(dist_target_r)),
    .head_target ($signed(head_target_r)),
    .derr_s3     (derr_s3),
    .dder_s3     (dder_s3),
    .herr_s3     (herr_s3),
    .hder_s3     (hder_s3),
    .settled_nxt (settled_nxt)
  );

  // Loop powers
  dpd_pow u_pow (
    .clk         (clk),
    .ctrl        (ctrl),
    .derr_s3     (derr_s3),
    .dder_s3     (dder_s3),
    .herr_s3     (herr_s3),
    .hder_s3     (hder_s3),
    .settled_nxt (settled_nxt),
    .lat_p_gain  (lat_p_gain_r),
    .lat_d_gain  (lat_d_gain_r),
    .turn_p_gain (turn_p_gain_r),
    .turn_d_gain (turn_d_gain_r),
    .lat_limit   (lat_limit_r),
    .turn_limit  (turn_limit_r),
    .lat_pow     (lat_pow),
    .turn_pow    (turn_pow),
    .settled_s6  (settled_s6)
  );

  // Result stage: mix lateral and turn power into the two drives.
  always_ff @(posedge clk) begin
    if (ctrl.ld_out) begin
      left_drive_r  <= {lat_pow[dpd_pkg::DataW-1], lat_pow}
                     + {turn_pow[dpd_pkg::DataW-1], turn_pow};
      right_drive_r <= {lat_pow[dpd_pkg::DataW-1], lat_pow}
                     - {turn_pow[dpd_pkg::DataW-1], turn_pow};
      settled_r     <= settled_s6;
    end
  end

  assign out_left_drive  = left_drive_r;
  assign out_right_drive = right_drive_r;
  assign out_settled     = settled_r;

endmodule

`default_nettype wire

/* tb/sv/drive_checker.sv */
// Drive checker: predicts each drive result from the accepted samples and compares it.
`timescale 1ns / 100ps

module drive_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [dpd_pkg::DataW-1:0]   in_left_rotation,
  input  logic signed [dpd_pkg::DataW-1:0]   in_right_rotation,
  input  logic signed [dpd_pkg::DataW-1:0]   in_heading,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [dpd_pkg::DriveW-1:0]  out_left_drive,
  input  logic signed [dpd_pkg::DriveW-1:0]  out_right_drive,
  input  logic                               out_settled,
  input  logic                               cfg_we,
  input  logic [dpd_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [dpd_pkg::DataW-1:0]          cfg_wdata,
  output int                                 fail_count,
  output int                                 pending
);

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;

  typedef struct {
    logic [dpd_pkg::DriveW-1:0] left_drive;
    logic [dpd_pkg::DriveW-1:0] right_drive;
    logic                       settled;
  } drive_item_t;

  // Drive items predicted but not yet seen on the result channel.
  drive_item_t expected_drives[$];
  drive_item_t want;
  int errors = 0;

  // Shadow copy of the configuration registers.
  logic [dpd_pkg::GainW-1:0]        lat_p_gain, lat_d_gain, turn_p_gain, turn_d_gain;
  logic [dpd_pkg::GainW-1:0]        lat_limit, turn_limit;
  logic signed [dpd_pkg::DataW-1:0] dist_target, head_target;

  // Loop state of the controller.
  longint     prev_dist_err, prev_head_err;
  logic [2:0] close_cnt;
  logic [5:0] still_cnt;
  logic       done;

  function automatic longint clip32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint abs_val(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Gain times error in Q16.16, rounded toward minus infinity, then saturated.
  function automatic longint scaled_term(input logic [dpd_pkg::GainW-1:0] gain,
                                         input longint x);
    longint g;
    g = 0;
    g[dpd_pkg::GainW-1:0] = gain;
    return clip32((g * x) >>> 16);
  endfunction

  function automatic longint clamp_power(input longint v,
                                         input logic [dpd_pkg::GainW-1:0] lim);
    longint l;
    l = 0;
    l[dpd_pkg::GainW-1:0] = lim;
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  // Run both PD loops and the settle counters for one sample.
  task automatic predict_drive(input logic signed [dpd_pkg::DataW-1:0] l, r, h);
    longint avg, derr, dder, herr, hder, lat, trn;
    logic [63:0] sum, diff;
    drive_item_t item;
    avg  = (longint'(l) + longint'(r)) >>> 1;
    derr = clip32(longint'(dist_target) - avg);
    dder = clip32(derr - prev_dist_err);
    herr = clip32(longint'(head_target) - longint'(h));
    hder = clip32(herr - prev_head_err);
    lat  = clip32(scaled_term(lat_p_gain, derr) + scaled_term(lat_d_gain, dder));
    trn  = clip32(scaled_term(turn_p_gain, herr) + scaled_term(turn_d_gain, hder));
    lat  = clamp_power(lat, lat_limit);
    trn  = clamp_power(trn, turn_limit);

    // Close counter needs a small distance error and a small heading change.
    if (abs_val(derr) <= dpd_pkg::CLOSE_TOL && abs_val(hder) <= dpd_pkg::TURN_DER_TOL) begin
      if (close_cnt < dpd_pkg::CLOSE_NEED) close_cnt = close_cnt + 1'b1;
    end else begin
      close_cnt = '0;
    end
    // Still counter needs a small change of the distance error.
    if (abs_val(dder) <= dpd_pkg::STILL_TOL) begin
      if (still_cnt < dpd_pkg::STILL_NEED) still_cnt = still_cnt + 1'b1;
    end else begin
      still_cnt = '0;
    end
    if (close_cnt >= dpd_pkg::CLOSE_NEED || still_cnt >= dpd_pkg::STILL_NEED) done = 1'b1;

    prev_dist_err = derr;
    prev_head_err = herr;

    sum  = lat + trn;
    diff = lat - trn;
    item.left_drive  = sum[dpd_pkg::DriveW-1:0];
    item.right_drive = diff[dpd_pkg::DriveW-1:0];
    item.settled     = done;
    expected_drives.push_back(item);
  endtask

  task automatic check_field(input string name, input logic [dpd_pkg::DriveW-1:0] want_v,
                             input logic [dpd_pkg::DriveW-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d",
               $time, name, $signed(want_v), $signed(got_v));
    end
  endtask

  // Watch configuration writes, accepted samples and accepted results.
  always @(posedge clk) begin
    if (!rst_n) begin
      lat_p_gain    = dpd_pkg::RST_LAT_P_GAIN;
      lat_d_gain    = dpd_pkg::RST_LAT_D_GAIN;
      turn_p_gain   = dpd_pkg::RST_TURN_P_GAIN;
      turn_d_gain   = dpd_pkg::RST_TURN_D_GAIN;
      dist_target   = dpd_pkg::RST_DIST_TARGET;
      head_target   = dpd_pkg::RST_HEAD_TARGET;
      lat_limit     = dpd_pkg::RST_LAT_LIMIT;
      turn_limit    = dpd_pkg::RST_TURN_LIMIT;
      prev_dist_err = 0;
      prev_head_err = 0;
      close_cnt     = '0;
      still_cnt     = '0;
      done          = 1'b0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dpd_pkg::REG_LAT_P_GAIN:  lat_p_gain  = cfg_wdata[dpd_pkg::GainW-1:0];
          dpd_pkg::REG_LAT_D_GAIN:  lat_d_gain  = cfg_wdata[dpd_pkg::GainW-1:0];
          dpd_pkg::REG_TURN_P_GAIN: turn_p_gain = cfg_wdata[dpd_pkg::GainW-1:0];
          dpd_pkg::REG_TURN_D_GAIN: turn_d_gain = cfg_wdata[dpd_pkg::GainW-1:0];
          dpd_pkg::REG_DIST_TARGET: dist_target = cfg_wdata;
          dpd_pkg::REG_HEAD_TARGET: head_target = cfg_wdata;
          dpd_pkg::REG_LAT_LIMIT:   lat_limit   = cfg_wdata[dpd_pkg::GainW-1:0];
          dpd_pkg::REG_TURN_LIMIT:  turn_limit  = cfg_wdata[dpd_pkg::GainW-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_drive(in_left_rotation, in_right_rotation, in_heading);
      end
      if (out_valid && !out_stall) begin
        if (expected_drives.size() == 0) begin
          errors++;
          $display("%0t: unexpected drive item: expected none, actual %0d %0d %0b",
                   $time, out_left_drive, out_right_drive, out_settled);
        end else begin
          want = expected_drives.pop_front();
          check_field("left_drive", want.left_drive, out_left_drive);
          check_field("right_drive", want.right_drive, out_right_drive);
          check_field("settled", {{(dpd_pkg::DriveW-1){1'b0}}, want.settled},
                      {{(dpd_pkg::DriveW-1){1'b0}}, out_settled});
        end
      end
    end
    pending    <= expected_drives.size();
    fail_count <= errors;
  end

endmodule

/* tb/sv/tb.sv */
// Testbench top: drives samples and register settings into the drive controller.
`timescale 1ns / 100ps

module tb;

  localparam int NUM_REGS       = 1 << dpd_pkg::CfgIdxW;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 235;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 20;
  localparam int TIMEOUT_NS     = 400000;
  localparam logic signed [dpd_pkg::DataW-1:0] S_MAX = 32'sh7fff_ffff;
  localparam logic signed [dpd_pkg::DataW-1:0] S_MIN = 32'sh8000_0000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [dpd_pkg::DataW-1:0]  in_left_rotation = '0;
  logic signed [dpd_pkg::DataW-1:0]  in_right_rotation = '0;
  logic signed [dpd_pkg::DataW-1:0]  in_heading = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [dpd_pkg::DriveW-1:0] out_left_drive;
  logic signed [dpd_pkg::DriveW-1:0] out_right_drive;
  logic                              out_settled;
  logic                              cfg_we = 1'b0;
  logic [dpd_pkg::CfgIdxW-1:0]       cfg_index = '0;
  logic [dpd_pkg::DataW-1:0]         cfg_wdata = '0;
  int                                fail_count;
  int                                pending;

  // Stimulus side state.
  logic [dpd_pkg::DataW-1:0]        reg_plan [0:NUM_REGS-1];
  logic signed [dpd_pkg::DataW-1:0] dist_goal = dpd_pkg::RST_DIST_TARGET;
  logic signed [dpd_pkg::DataW-1:0] head_goal = dpd_pkg::RST_HEAD_TARGET;
  bit                               steady = 1'b0;
  int                               hold_requests = 0;
  int                               holds_done = 0;
  int                               phase;
  int                               idx;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  dual_pd_drive_controller_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_rotation(in_left_rotation), .in_right_rotation(in_right_rotation),
    .in_heading(in_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_drive(out_left_drive), .out_right_drive(out_right_drive),
    .out_settled(out_settled),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  drive_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_rotation(in_left_rotation), .in_right_rotation(in_right_rotation),
    .in_heading(in_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_drive(out_left_drive), .out_right_drive(out_right_drive),
    .out_settled(out_settled),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // Hard limit on run time.
  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  // Result receiver: random stalls, a long hold-off on request, none while steady.
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != hold_requests) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else if (steady) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 14);
      end
    end
  end

  // Offer one item and wait until it is taken.
  task automatic send_sample(input logic signed [dpd_pkg::DataW-1:0] l, r, h);
    in_valid          <= 1'b1;
    in_left_rotation  <= l;
    in_right_rotation <= r;
    in_heading        <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random idle cycles on the input side.
  task automatic offer(input logic signed [dpd_pkg::DataW-1:0] l, r, h);
    if (!steady && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(2, 6) : 1) @(posedge clk);
    end
    send_sample(l, r, h);
  endtask

  // Stop offering until every predicted item has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dpd_pkg::CfgIdxW-1:0] index,
                           input logic [dpd_pkg::DataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Write every register from the plan; the block must be idle.
  task automatic load_plan();
    int i;
    for (i = 0; i < NUM_REGS; i++) write_reg(i[dpd_pkg::CfgIdxW-1:0], reg_plan[i]);
    cfg_we    <= 1'b0;
    dist_goal = reg_plan[dpd_pkg::REG_DIST_TARGET];
    head_goal = reg_plan[dpd_pkg::REG_HEAD_TARGET];
    @(posedge clk);
  endtask

  // Signed value of random magnitude, from tiny to full scale.
  function automatic logic signed [dpd_pkg::DataW-1:0] rand_offset();
    logic signed [dpd_pkg::DataW-1:0] mag;
    mag = $urandom >> $urandom_range(1, 31);
    return $urandom_range(1) ? -mag : mag;
  endfunction

  function automatic logic [dpd_pkg::DataW-1:0] rand_gain();
    case ($urandom_range(3))
      0: return $urandom_range(0, 32'h0004_0000);
      1: return $urandom;
      2: return $urandom_range(0, 32'h00c8_0000);
      default: return '0;
    endcase
  endfunction

  // A run of samples that closes in on both targets, optionally with one spike.
  task automatic send_converging(input int len, input bit broken);
    logic signed [dpd_pkg::DataW-1:0] off_d, off_h, skew, l, r, h;
    int spike_at, k, jit;
    off_d    = rand_offset();
    off_h    = rand_offset();
    spike_at = broken ? $urandom_range(0, len - 1) : -1;
    for (k = 0; k < len; k++) begin
      skew = rand_offset() >>> $urandom_range(8, 24);
      l = dist_goal + off_d + skew;
      r = dist_goal + off_d - skew;
      h = head_goal - off_h;
      if (k == spike_at) begin
        case ($urandom_range(2))
          0: l = $urandom;
          1: r = $urandom;
          default: h = $urandom;
        endcase
      end
      offer(l, r, h);
      off_d = off_d >>> 1;
      off_h = off_h >>> 1;
      if ($urandom_range(3) == 0) begin
        jit   = $urandom_range(0, 400);
        off_d = off_d + jit - 200;
      end
    end
  endtask

  // Mix of converging runs, broken runs and pure noise.
  task automatic run_random(input int count);
    int sent, len, pick, k;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) offer($urandom, $urandom, $urandom);
      end else begin
        len = $urandom_range(6, 40);
        send_converging(len, pick < 35);
      end
      sent += len;
    end
  endtask

  // Main stimulus.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed samples at reset settings: field extremes, floor of the average,
    // and the settle tolerances hit exactly and missed by one.
    offer(S_MAX, S_MAX, S_MAX);
    offer(S_MIN, S_MIN, S_MIN);
    offer(S_MAX, S_MIN, 32'sd0);
    offer(-32'sd1, 32'sd0, head_goal);
    offer(32'sd1, 32'sd0, head_goal);
    offer(-32'sd655, -32'sd655, head_goal);
    offer(32'sd655, 32'sd655, head_goal - 32'sd6553);
    offer(32'sd0, 32'sd0, head_goal);
    offer(32'sd0, 32'sd0, head_goal - 32'sd6554);
    offer(32'sd0, 32'sd0, head_goal);
    offer(32'sd0, 32'sd0, head_goal);
    offer(-32'sd656, -32'sd656, head_goal);
    offer(32'sd0, 32'sd0, head_goal);
    offer(32'sd0, 32'sd0, head_goal);
    offer(32'sd0, 32'sd0, head_goal);
    offer(-32'sd655, -32'sd656, head_goal);
    offer(-32'sd654, -32'sd655, head_goal);
    offer(S_MAX, -32'sd1, S_MAX);

    // Each phase starts from an idle block with new settings.
    for (phase = 0; phase < PHASES; phase++) begin
      drain();
      if (phase == 0) begin
        // Largest gains and limits; bit 31 of the gains must be dropped.
        reg_plan[dpd_pkg::REG_LAT_P_GAIN]  = 32'hffff_ffff;
        reg_plan[dpd_pkg::REG_LAT_D_GAIN]  = 32'hffff_ffff;
        reg_plan[dpd_pkg::REG_TURN_P_GAIN] = 32'hffff_ffff;
        reg_plan[dpd_pkg::REG_TURN_D_GAIN] = 32'hffff_ffff;
        reg_plan[dpd_pkg::REG_DIST_TARGET] = S_MAX;
        reg_plan[dpd_pkg::REG_HEAD_TARGET] = S_MIN;
        reg_plan[dpd_pkg::REG_LAT_LIMIT]   = 32'hffff_ffff;
        reg_plan[dpd_pkg::REG_TURN_LIMIT]  = 32'hffff_ffff;
      end else if (phase == 1) begin
        reg_plan[dpd_pkg::REG_LAT_P_GAIN]  = '0;
        reg_plan[dpd_pkg::REG_LAT_D_GAIN]  = '0;
        reg_plan[dpd_pkg::REG_TURN_P_GAIN] = 32'h7fff_ffff;
        reg_plan[dpd_pkg::REG_TURN_D_GAIN] = 32'h7fff_ffff;
        reg_plan[dpd_pkg::REG_DIST_TARGET] = S_MIN;
        reg_plan[dpd_pkg::REG_HEAD_TARGET] = S_MAX;
        reg_plan[dpd_pkg::REG_LAT_LIMIT]   = '0;
        reg_plan[dpd_pkg::REG_TURN_LIMIT]  = 32'h7fff_ffff;
      end else if (phase == 2) begin
        reg_plan[dpd_pkg::REG_LAT_P_GAIN]  = dpd_pkg::RST_LAT_P_GAIN;
        reg_plan[dpd_pkg::REG_LAT_D_GAIN]  = 32'h0001_0000;
        reg_plan[dpd_pkg::REG_TURN_P_GAIN] = dpd_pkg::RST_TURN_P_GAIN;
        reg_plan[dpd_pkg::REG_TURN_D_GAIN] = dpd_pkg::RST_TURN_D_GAIN;
        reg_plan[dpd_pkg::REG_DIST_TARGET] = rand_offset();
        reg_plan[dpd_pkg::REG_HEAD_TARGET] = rand_offset();
        reg_plan[dpd_pkg::REG_LAT_LIMIT]   = dpd_pkg::RST_LAT_LIMIT;
        reg_plan[dpd_pkg::REG_TURN_LIMIT]  = dpd_pkg::RST_TURN_LIMIT;
      end else begin
        for (idx = 0; idx < NUM_REGS; idx++) reg_plan[idx] = rand_gain();
        reg_plan[dpd_pkg::REG_DIST_TARGET] = $urandom_range(1) ? $urandom : rand_offset();
        reg_plan[dpd_pkg::REG_HEAD_TARGET] = $urandom_range(1) ? $urandom : rand_offset();
      end
      load_plan();

      // One phase runs with no idling on either side.
      steady = (phase == 3);
      // Long receiver hold-off while the sender keeps offering.
      if (phase == 2 || phase == 5) hold_requests++;
      run_random(PHASE_ITEMS);
      steady = 1'b0;
    end

    // Wait for the last results, then a few more cycles for strays.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/dpd_pkg.sv
src/dpd_pipe_ctrl.sv
src/dpd_err.sv
src/dpd_pow.sv
src/dual_pd_drive_controller_unit.sv
tb/sv/drive_checker.sv
tb/sv/tb.sv
